[design/asids_pkg.sv]
// ----------------------------------------------------------------------------
// asids_pkg
// shared constants and types for the packed list store
// ----------------------------------------------------------------------------
package asids_pkg;

  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW = AddrW + 1;

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_GET = 3'd3;
  localparam logic [2:0] ACT_SET = 3'd4;
  localparam logic [2:0] ACT_SEARCH = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // memory access request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [31:0]      wr_data;
  } mem_req_t;

endpackage

[design/asids_mem.sv]
// ----------------------------------------------------------------------------
// asids_mem
// entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module asids_mem (
  input  logic                 clk,
  input  asids_pkg::mem_req_t  req,
  output logic [31:0]          rd_data
);

  logic [31:0] mem [asids_pkg::Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[design/asids_seq.sv]
// ----------------------------------------------------------------------------
// asids_seq
// sequencer: shifts entries one per step and runs the binary search probes
// ----------------------------------------------------------------------------
module asids_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [6:0]                   cfg_data,
  input  logic                         in_go,
  input  logic [2:0]                   in_action,
  input  logic [6:0]                   in_index,
  input  logic [31:0]                  in_value,
  output logic                         busy,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [31:0]                  res_value,
  output logic [1:0]                   res_status,
  output logic [6:0]                   res_count,
  output asids_pkg::mem_req_t          req,
  input  logic [31:0]                  rd_data
);

  localparam int CW = asids_pkg::CntW;
  localparam int AW = asids_pkg::AddrW;

  typedef enum logic [2:0] {S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_READ, S_SRCH_RD,
                            S_SRCH_CMP, S_DONE} state_t;

  state_t        state;
  logic [6:0]    capacity;
  logic [CW-1:0] fill;
  logic [2:0]    act;
  logic [CW-1:0] idx;
  logic [31:0]   key;
  logic [CW-1:0] ptr;
  logic [CW:0]   lo;
  logic [CW:0]   hi;
  logic [CW:0]   mid;

  logic [CW-1:0] limit;
  logic [CW-1:0] in_idx;
  logic          in_range;

  assign limit = (capacity < 7'(asids_pkg::Depth)) ? CW'(capacity) : CW'(asids_pkg::Depth);
  assign in_idx = CW'(in_index);
  assign in_range = (7'(in_index) < 7'(fill));
  assign busy = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  // memory request
  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        req.rd_en = in_go;
        req.rd_addr = in_index[AW-1:0];
        req.wr_en = in_go && (in_action == asids_pkg::ACT_APPEND) &&
                    (fill < limit);
        req.wr_addr = fill[AW-1:0];
        req.wr_data = in_value;
        if (in_go && (in_action == asids_pkg::ACT_SET) && in_range) begin
          req.wr_en = 1'b1;
          req.wr_addr = in_index[AW-1:0];
        end
      end
      S_SHIFT_RD: begin
        req.rd_en = 1'b1;
        req.rd_addr = (act == asids_pkg::ACT_INSERT) ? AW'(ptr - 1'b1) : AW'(ptr + 1'b1);
      end
      S_SHIFT_WR: begin
        req.wr_en = 1'b1;
        req.wr_addr = ptr[AW-1:0];
        req.wr_data = rd_data;
      end
      S_SRCH_RD: begin
        req.rd_en = 1'b1;
        req.rd_addr = mid[AW-1:0];
      end
      default: req = '0;
    endcase
    if (state == S_SHIFT_RD && act == asids_pkg::ACT_INSERT && ptr == idx) begin
      req.rd_en = 1'b0;
      req.wr_en = 1'b1;
      req.wr_addr = ptr[AW-1:0];
      req.wr_data = key;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= 7'd64;
      fill <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_go) begin
            act <= in_action;
            idx <= in_idx;
            key <= in_value;
            res_value <= '0;
            res_status <= asids_pkg::ST_OK;
            res_count <= 7'(fill);
            state <= S_DONE;
            case (in_action)
              asids_pkg::ACT_APPEND: begin
                if (fill < limit) begin
                  fill <= fill + 1'b1;
                  res_count <= 7'(fill + 1'b1);
                end else begin
                  res_status <= asids_pkg::ST_FULL;
                end
              end
              asids_pkg::ACT_INSERT: begin
                if (7'(in_index) > 7'(fill)) begin
                  res_status <= asids_pkg::ST_RANGE;
                end else if (fill >= limit) begin
                  res_status <= asids_pkg::ST_FULL;
                end else begin
                  ptr <= fill;
                  state <= S_SHIFT_RD;
                end
              end
              asids_pkg::ACT_DELETE, asids_pkg::ACT_GET: begin
                if (in_range) begin
                  ptr <= in_idx;
                  state <= S_READ;
                end else begin
                  res_status <= asids_pkg::ST_RANGE;
                  if (in_action == asids_pkg::ACT_GET) begin
                    res_value <= '1;
                  end
                end
              end
              asids_pkg::ACT_SET: begin
                if (!in_range) begin
                  res_status <= asids_pkg::ST_RANGE;
                end
              end
              asids_pkg::ACT_SEARCH: begin
                lo <= '0;
                hi <= (CW+1)'(fill) - 1'b1;
                state <= S_SRCH_RD;
              end
              default: ;
            endcase
          end
        end
        // removed or read word is now on the read port
        S_READ: begin
          res_value <= rd_data;
          if (act == asids_pkg::ACT_DELETE) begin
            state <= S_SHIFT_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHIFT_RD: begin
          if (act == asids_pkg::ACT_INSERT) begin
            if (ptr == idx) begin
              fill <= fill + 1'b1;
              res_count <= 7'(fill + 1'b1);
              state <= S_DONE;
            end else begin
              state <= S_SHIFT_WR;
            end
          end else if (ptr + 1'b1 >= fill) begin
            fill <= fill - 1'b1;
            res_count <= 7'(fill - 1'b1);
            state <= S_DONE;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          ptr <= (act == asids_pkg::ACT_INSERT) ? ptr - 1'b1 : ptr + 1'b1;
          state <= S_SHIFT_RD;
        end
        S_SRCH_RD: begin
          if ($signed(lo) > $signed(hi)) begin
            res_value <= '1;
            res_status <= asids_pkg::ST_MISS;
            state <= S_DONE;
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        // one probe word compared with the key per probe
        S_SRCH_CMP: begin
          if (rd_data == key) begin
            res_value <= 32'(mid);
            state <= S_DONE;
          end else begin
            if ($signed(key) < $signed(rd_data)) begin
              hi <= mid - 1'b1;
            end else begin
              lo <= mid + 1'b1;
            end
            state <= S_SRCH_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mid = (lo + hi) >> 1;

endmodule

[design/array_store_insert_delete_search_top.sv]
// ----------------------------------------------------------------------------
// array_store_insert_delete_search_top
// packed list of signed words with insert, delete, get, set and search
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   tdata: action[2:0], index[9:3], value[41:10]
// m_axis   out  tdata: result_value[31:0], status[33:32], count[40:34]
// cfg      in   cfg_we, cfg_data: capacity
//
// append, set and rejected requests show the result word the cycle after accept
// get passes through S_READ first to take the registered memory read
// insert and delete move one entry per S_SHIFT_RD / S_SHIFT_WR pair
// search runs each probe through S_SRCH_RD and S_SRCH_CMP, at most log2(64)+1 probes
// one request at a time; s_axis_tready is low until the result is taken
// rst is synchronous; it empties the list and sets capacity to 64
module array_store_insert_delete_search_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // action, index, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // result_value, status, count
);

  asids_pkg::mem_req_t req;
  logic [31:0] rd_data;
  logic        busy;
  logic [31:0] res_value;
  logic [1:0]  res_status;
  logic [6:0]  res_count;

  assign s_axis_tready = !busy;

  asids_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_go     (s_axis_tvalid && s_axis_tready),
    .in_action (s_axis_tdata[2:0]),
    .in_index  (s_axis_tdata[9:3]),
    .in_value  (s_axis_tdata[41:10]),
    .busy      (busy),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_value (res_value),
    .res_status(res_status),
    .res_count (res_count),
    .req       (req),
    .rd_data   (rd_data)
  );

  asids_mem u_mem (
    .clk    (clk),
    .req    (req),
    .rd_data(rd_data)
  );

  assign m_axis_tdata = {7'd0, res_count, res_status, res_value};

`ifndef SYNTHESIS
  // no new word accepted while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  // count never exceeds depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[40:34] <= 7'd64)) else $error("count over depth");
  // result leaves only when taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
`endif

endmodule
